[design/utf8d_pkg.sv]
// Shared types, constants and the lead byte length function of the UTF-8 decoder.
`default_nettype none

package utf8d_pkg;

	// Widths of the stream fields.
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned CP_W        = 21;
	localparam int unsigned OUT_TDATA_W = 24;
	localparam int unsigned LEN_W       = 3;

	// Default longest sequence and largest number of results per input byte.
	localparam int unsigned DEF_MAX_SEQUENCE = 6;
	localparam int unsigned MAX_RESULTS      = 4;

	// Code point limits.
	localparam logic [CP_W-1:0] REPL_CHAR = 21'h00FFFD;
	localparam logic [CP_W-1:0] MAX_CP    = 21'h10FFFF;
	localparam logic [CP_W-1:0] SURR_LO   = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI   = 21'h00DFFF;

	// Byte values that bound the second byte and the lead.
	localparam logic [7:0] CONT_LO   = 8'h80;
	localparam logic [7:0] CONT_HI   = 8'hBF;
	localparam logic [7:0] LEAD_E0   = 8'hE0;
	localparam logic [7:0] LEAD_ED   = 8'hED;
	localparam logic [7:0] LEAD_F0   = 8'hF0;
	localparam logic [7:0] LEAD_F4   = 8'hF4;
	localparam logic [7:0] MIN_AFTER_E0 = 8'hA0;
	localparam logic [7:0] MAX_AFTER_ED = 8'h9F;
	localparam logic [7:0] MIN_AFTER_F0 = 8'h90;
	localparam logic [7:0] MAX_AFTER_F4 = 8'h8F;
	localparam logic [7:0] MIN_LEAD  = 8'hC2;

	// One queued input byte with its classification.
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              eot;
		logic [LEN_W-1:0]  len;
	} item_t;

	// One result item.
	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            is_replacement;
		logic            last_of_run;
		logic            text_done;
	} result_t;

	// Sequence length that a lead byte asks for, capped at max_seq.
	function automatic logic [LEN_W-1:0] seq_length(input logic [7:0] b,
		input int unsigned max_seq);
		logic [LEN_W-1:0] n;
		logic [LEN_W-1:0] cap;
		cap = LEN_W'(max_seq);
		if (b < 8'hC0) begin
			n = LEN_W'(1);
		end else if (b < 8'hE0) begin
			n = LEN_W'(2);
		end else if (b < 8'hF0) begin
			n = LEN_W'(3);
		end else if (b < 8'hF8) begin
			n = LEN_W'(4);
		end else if (b < 8'hFC) begin
			n = LEN_W'(5);
		end else begin
			n = LEN_W'(6);
		end
		if (n > cap) begin
			n = cap;
		end
		return n;
	endfunction

endpackage

`default_nettype wire

[design/utf8d_front.sv]
// Input side of the UTF-8 decoder: accepts bytes, classifies them and queues them.
`default_nettype none

module utf8d_front import utf8d_pkg::*; #(
	parameter int unsigned MAX_SEQUENCE = DEF_MAX_SEQUENCE
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [BYTE_W-1:0] s_tdata,
	input  wire logic              s_tlast,
	output logic                   q_valid,
	output item_t                  q_item,
	input  wire logic              q_pop
);

	localparam int unsigned DEPTH = 2;

	item_t      fifo_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;
	item_t      new_item;

	// Classify the incoming byte as if it were a lead.
	always_comb begin
		new_item.data = s_tdata;
		new_item.eot  = s_tlast;
		new_item.len  = seq_length(s_tdata, MAX_SEQUENCE);
	end

	assign s_tready = (cnt_q != 2'(DEPTH));
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_pop && q_valid;
	assign q_item   = fifo_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= new_item;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

[design/utf8d_back.sv]
// Back side of the UTF-8 decoder: holds bytes, judges sequences and drives results.
`default_nettype none

module utf8d_back import utf8d_pkg::*; #(
	parameter int unsigned MAX_SEQUENCE = DEF_MAX_SEQUENCE
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  q_valid,
	input  wire item_t q_item,
	output logic       q_pop,
	output logic       out_valid,
	input  wire logic  out_ready,
	output result_t    out_res
);

	localparam int unsigned CNT_W  = $clog2(MAX_SEQUENCE + 1);
	localparam int unsigned HELD_W = MAX_SEQUENCE * BYTE_W;
	localparam int unsigned EMIT_W = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		ST_LOAD = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t             state_q;
	logic [HELD_W-1:0]  held_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   need_q;
	logic               eot_q;
	logic [EMIT_W-1:0]  emit_cnt_q;
	logic               out_valid_q;
	result_t            out_q;

	logic [7:0]              lead;
	logic [7:0]              b1;
	logic [7:0]              b2;
	logic [7:0]              b3;
	logic [MAX_SEQUENCE-1:0] bad;
	logic [CNT_W-1:0]        k_bad;
	logic                    any_bad;
	logic [CP_W-1:0]         dec;
	logic                    range_bad;
	logic [CNT_W-1:0]        k;
	logic                    rep;
	logic [CP_W-1:0]         cp;
	logic [CNT_W-1:0]        cnt_n;
	logic [HELD_W-1:0]       held_sh;
	logic [CNT_W-1:0]        need_n;
	logic                    more;
	logic                    step_en;
	logic                    emit_en;
	logic                    last;
	logic [HELD_W-1:0]       held_ld;
	logic [CNT_W-1:0]        cnt_ld;
	logic [CNT_W-1:0]        need_ld;
	logic                    work_ld;

	assign lead = held_q[7:0];
	assign b1   = held_q[15:8];
	assign b2   = held_q[23:16];
	assign b3   = held_q[31:24];

	// Check each trailing position on its own.
	always_comb begin
		logic [7:0] a;
		bad = '0;
		for (int i = 1; i < MAX_SEQUENCE; i++) begin
			a = held_q[i*BYTE_W +: BYTE_W];
			if (i >= 2) begin
				bad[i] = (a < CONT_LO) || (a > CONT_HI);
			end else if (a > CONT_HI) begin
				bad[i] = 1'b1;
			end else begin
				unique case (lead)
					LEAD_E0: bad[i] = (a < MIN_AFTER_E0);
					LEAD_ED: bad[i] = (a > MAX_AFTER_ED);
					LEAD_F0: bad[i] = (a < MIN_AFTER_F0);
					LEAD_F4: bad[i] = (a > MAX_AFTER_F4);
					default: bad[i] = (a < CONT_LO);
				endcase
			end
		end
	end

	// The highest failing position inside the sequence wins.
	always_comb begin
		k_bad   = '0;
		any_bad = 1'b0;
		for (int i = 1; i < MAX_SEQUENCE; i++) begin
			if ((CNT_W'(i) < need_q) && bad[i]) begin
				k_bad   = CNT_W'(i);
				any_bad = 1'b1;
			end
		end
	end

	// Assemble the code point from the payload bits of each byte.
	always_comb begin
		unique case (need_q)
			CNT_W'(1): dec = {13'd0, lead};
			CNT_W'(2): dec = {10'd0, lead[4:0], b1[5:0]};
			CNT_W'(3): dec = {5'd0, lead[3:0], b1[5:0], b2[5:0]};
			CNT_W'(4): dec = {lead[2:0], b1[5:0], b2[5:0], b3[5:0]};
			default:   dec = '0;
		endcase
		range_bad = (dec > MAX_CP) || ((dec >= SURR_LO) && (dec <= SURR_HI));
	end

	// Judge the held sequence: bytes consumed and the value to report.
	always_comb begin
		k   = need_q;
		rep = 1'b1;
		cp  = REPL_CHAR;
		priority if (cnt_q < need_q) begin
			// Cut off by the end of the text.
			k = cnt_q;
		end else if (need_q > CNT_W'(4)) begin
			k = need_q;
		end else if (any_bad) begin
			k = k_bad;
		end else if ((lead >= CONT_LO) && (lead < MIN_LEAD)) begin
			k = CNT_W'(1);
		end else if (lead > LEAD_F4) begin
			k = need_q;
		end else begin
			k   = need_q;
			rep = range_bad;
			cp  = range_bad ? REPL_CHAR : dec;
		end
	end

	// Drop consumed bytes and look at what stays.
	always_comb begin
		cnt_n   = cnt_q - k;
		held_sh = held_q >> {k, 3'b000};
		need_n  = (cnt_n == '0) ? '0 : CNT_W'(seq_length(held_sh[7:0], MAX_SEQUENCE));
		more    = (cnt_n != '0) && (eot_q || (cnt_n >= need_n));
	end

	assign step_en = (state_q == ST_RUN) && (!out_valid_q || out_ready);
	assign emit_en = step_en && (emit_cnt_q < EMIT_W'(MAX_RESULTS));
	assign last    = !more || (emit_cnt_q == EMIT_W'(MAX_RESULTS - 1));
	assign q_pop   = (state_q == ST_LOAD) && q_valid;

	// Append a byte from the queue.
	always_comb begin
		held_ld = held_q;
		for (int j = 0; j < MAX_SEQUENCE; j++) begin
			if (CNT_W'(j) == cnt_q) begin
				held_ld[j*BYTE_W +: BYTE_W] = q_item.data;
			end
		end
		cnt_ld  = (cnt_q < CNT_W'(MAX_SEQUENCE)) ? cnt_q + CNT_W'(1) : cnt_q;
		need_ld = (need_q == '0) ? CNT_W'(q_item.len) : need_q;
		work_ld = (cnt_ld >= need_ld) || q_item.eot;
	end

	// Held bytes and result payload.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			held_q <= held_ld;
		end else if (step_en) begin
			held_q <= held_sh;
		end
		if (emit_en) begin
			out_q.code_point     <= cp;
			out_q.is_replacement <= rep;
			out_q.last_of_run    <= last;
			out_q.text_done      <= last && eot_q;
		end
	end

	// Sequencer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			need_q      <= '0;
			eot_q       <= 1'b0;
			emit_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (q_pop) begin
						cnt_q      <= cnt_ld;
						need_q     <= need_ld;
						eot_q      <= q_item.eot;
						emit_cnt_q <= '0;
						if (work_ld) begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (step_en) begin
						cnt_q  <= cnt_n;
						need_q <= need_n;
						if (emit_en) begin
							emit_cnt_q <= emit_cnt_q + EMIT_W'(1);
						end
						if (!more) begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

`default_nettype wire

[design/utf8_to_code_point_decoder_unit.sv]
// Top level of the UTF-8 to code point decoder.
//
// Input stream: one text byte per transaction on s_tdata, s_tlast high on
// the final byte of the text. Output stream: one code point per transaction
// on m_tdata, m_tlast high on the last result caused by an input byte,
// m_tuser flags replacement results and the end of the text.
// Malformed input gives U+FFFD; the failing byte and those after it are
// decoded again. A byte that completes a sequence passes from the input
// queue into the held byte register, where the sequence is judged and its
// first result is written to the result register. The sequencer takes
// a byte in while loading and then steps through the results it causes;
// the two entry input queue lets input run ahead while results are written
// out.
// Reset empties the queue and the held bytes and drops any pending result.
// When m_tready is low the result register holds; the sequencer stops and
// the queue fills, after which s_tready falls.
`default_nettype none

module utf8_to_code_point_decoder_unit import utf8d_pkg::*; #(
	parameter int unsigned MAX_SEQUENCE = DEF_MAX_SEQUENCE
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [BYTE_W-1:0]      s_tdata,  // [7:0] data_byte
	input  wire logic                   s_tlast,  // end_of_text
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,  // [20:0] code_point, [23:21] zero
	output logic [1:0]                  m_tuser,  // [0] is_replacement, [1] text_done
	output logic                        m_tlast   // last_of_run
);

	logic    q_valid;
	item_t   q_item;
	logic    q_pop;
	result_t res;

	// Accept and classify bytes.
	utf8d_front #(
		.MAX_SEQUENCE(MAX_SEQUENCE)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	// Decode held sequences into results.
	utf8d_back #(
		.MAX_SEQUENCE(MAX_SEQUENCE)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (res)
	);

	assign m_tdata = {(OUT_TDATA_W - CP_W)'(0), res.code_point};
	assign m_tuser = {res.text_done, res.is_replacement};
	assign m_tlast = res.last_of_run;

	// The end of the text always closes the run of its byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast)
		else $error("text_done without last_of_run");

	// A replacement result always carries U+FFFD.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[CP_W-1:0] == REPL_CHAR)
		else $error("replacement result with wrong code point");

	// A decoded value is a Unicode scalar value.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |->
			(m_tdata[CP_W-1:0] <= MAX_CP) &&
			((m_tdata[CP_W-1:0] < SURR_LO) || (m_tdata[CP_W-1:0] > SURR_HI)))
		else $error("decoded code point out of range");

	// The queue never pops while it is empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty input queue");

endmodule

`default_nettype wire

[bench/tb.sv]
// Self-checking testbench for the UTF-8 to code point decoder.
`timescale 1ns / 100ps

module tb;
	import utf8d_pkg::*;

	localparam int unsigned SEQ_LIMIT   = 6;
	localparam int unsigned RESULT_CAP  = 4;
	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned DRAIN_TAIL  = 32;
	localparam int unsigned MAX_REPORTS = 10;

	// Kinds of text piece that the random part builds.
	typedef enum int unsigned {
		PIECE_VALID,
		PIECE_STRAY_BYTE,
		PIECE_CORRUPT_BYTE,
		PIECE_CUT_SHORT,
		PIECE_OVERLONG,
		PIECE_LONG_LEAD,
		PIECE_OUT_OF_RANGE
	} piece_kind_e;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [BYTE_W-1:0]      s_tdata = '0;     // [7:0] data_byte
	logic                   s_tlast = 1'b0;   // end_of_text
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;          // [20:0] code_point, [23:21] zero
	logic [1:0]             m_tuser;          // [0] is_replacement, [1] text_done
	logic                   m_tlast;          // last_of_run

	// Decoder state as the bench sees it, and the code points still owed.
	logic [7:0]  held_seq [SEQ_LIMIT];
	int unsigned held_len = 0;
	int unsigned want_len = 0;
	result_t     expected_points [$];

	// Sender and receiver pacing.
	int unsigned burst_left = 0;
	logic        gaps_on = 1'b1;
	logic        rx_steady = 1'b0;
	logic [15:0] rx_pattern = 16'hFFFF;
	logic [4:0]  rx_phase = '0;

	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	logic [7:0]  piece [$];

	utf8_to_code_point_decoder_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #6 clk = ~clk;

	// Sequence length asked for by a lead byte.
	function automatic int unsigned lead_length(input logic [7:0] b);
		int unsigned n;
		if (b < 8'hC0) begin
			n = 1;
		end else if (b < 8'hE0) begin
			n = 2;
		end else if (b < 8'hF0) begin
			n = 3;
		end else if (b < 8'hF8) begin
			n = 4;
		end else if (b < 8'hFC) begin
			n = 5;
		end else begin
			n = 6;
		end
		return (n > SEQ_LIMIT) ? SEQ_LIMIT : n;
	endfunction

	// Judges the first n held bytes and returns how many of them are consumed.
	function automatic int unsigned judge_held(input int unsigned n,
		output logic [CP_W-1:0] cp, output logic rep);
		logic [7:0]  lead;
		logic [7:0]  a;
		logic        bad;
		logic [31:0] acc;
		int unsigned i;
		lead = held_seq[0];
		cp = REPL_CHAR;
		rep = 1'b1;
		acc = '0;
		if (n > 4) begin
			return n;
		end
		// Trailing bytes are checked from the last one back to the second.
		for (i = n - 1; i >= 1; i--) begin
			a = held_seq[i];
			if (i >= 2) begin
				bad = (a < CONT_LO) || (a > CONT_HI);
			end else if (a > CONT_HI) begin
				bad = 1'b1;
			end else begin
				case (lead)
					LEAD_E0: bad = (a < MIN_AFTER_E0);
					LEAD_ED: bad = (a > MAX_AFTER_ED);
					LEAD_F0: bad = (a < MIN_AFTER_F0);
					LEAD_F4: bad = (a > MAX_AFTER_F4);
					default: bad = (a < CONT_LO);
				endcase
			end
			if (bad) begin
				return i;
			end
		end
		if (lead >= CONT_LO && lead < MIN_LEAD) begin
			return 1;
		end
		if (lead > LEAD_F4) begin
			return n;
		end
		for (i = 0; i + 1 < n; i++) begin
			acc = (acc + held_seq[i]) << 6;
		end
		acc = acc + held_seq[n-1];
		case (n)
			2: acc = acc - 32'h0000_3080;
			3: acc = acc - 32'h000E_2080;
			4: acc = acc - 32'h03C8_2080;
			default: acc = acc;
		endcase
		if (acc > 32'h10FFFF || (acc >= 32'hD800 && acc <= 32'hDFFF)) begin
			return n;
		end
		cp = acc[CP_W-1:0];
		rep = 1'b0;
		return n;
	endfunction

	// Takes one accepted byte and queues the code points that it releases.
	function automatic void decode_byte(input logic [7:0] b, input logic eot);
		result_t     run [$];
		result_t     r;
		logic [CP_W-1:0] cp;
		logic        rep;
		int unsigned k;
		int unsigned i;
		if (held_len < SEQ_LIMIT) begin
			held_seq[held_len] = b;
			held_len++;
		end
		if (held_len > 0 && want_len == 0) begin
			want_len = lead_length(held_seq[0]);
		end
		while (held_len > 0 && held_len >= want_len) begin
			k = judge_held(want_len, cp, rep);
			if (k > held_len) begin
				k = held_len;
			end
			r = '{code_point: cp, is_replacement: rep, last_of_run: 1'b0, text_done: 1'b0};
			if (run.size() < RESULT_CAP) begin
				run.push_back(r);
			end
			// Bytes behind the consumed ones are fed in again.
			for (i = 0; i + k < held_len; i++) begin
				held_seq[i] = held_seq[i+k];
			end
			held_len -= k;
			want_len = (held_len > 0) ? lead_length(held_seq[0]) : 0;
		end
		// A text that ends inside a sequence gives one replacement.
		if (eot && held_len > 0) begin
			r = '{code_point: REPL_CHAR, is_replacement: 1'b1, last_of_run: 1'b0,
				text_done: 1'b0};
			if (run.size() < RESULT_CAP) begin
				run.push_back(r);
			end
			held_len = 0;
			want_len = 0;
		end
		if (run.size() > 0) begin
			run[run.size()-1].last_of_run = 1'b1;
			run[run.size()-1].text_done = eot;
		end
		foreach (run[j]) begin
			expected_points.push_back(run[j]);
		end
	endfunction

	function automatic void note_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("MISMATCH at %0t: %s", $realtime, what);
		end
	endfunction

	// Both streams are sampled at the falling edge, where every signal is settled.
	always @(negedge clk) begin : watch_streams
		result_t want;
		logic    s_fire;
		logic    m_fire;
		s_fire = s_tvalid && s_tready;
		m_fire = m_tvalid && m_tready;
		if (arst_n) begin
			if (m_fire) begin
				if (expected_points.size() == 0) begin
					note_mismatch($sformatf("unexpected result cp %h rep %b last %b done %b",
						m_tdata, m_tuser[0], m_tlast, m_tuser[1]));
				end else begin
					want = expected_points.pop_front();
					if (m_tdata !== {3'b000, want.code_point} ||
						m_tuser[0] !== want.is_replacement ||
						m_tlast !== want.last_of_run ||
						m_tuser[1] !== want.text_done) begin
						note_mismatch($sformatf(
							"expected cp %h rep %b last %b done %b, got cp %h rep %b last %b done %b",
							want.code_point, want.is_replacement, want.last_of_run,
							want.text_done, m_tdata, m_tuser[0], m_tlast, m_tuser[1]));
					end
				end
			end
			if (s_fire) begin
				decode_byte(s_tdata, s_tlast);
			end
			// Watchdog on cycles in which neither side completes a transaction.
			quiet_cycles = (s_fire || m_fire) ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Receiver stalls follow a rotating pattern that is reloaded each time the five bit phase counter wraps.
	always @(posedge clk) begin
		if (rx_phase == 0) begin
			case ($urandom_range(0, 3))
				0: rx_pattern <= 16'hFFFF;
				1: rx_pattern <= 16'($urandom()) | 16'h0001;
				2: rx_pattern <= 16'($urandom() | $urandom()) | 16'h0001;
				default: rx_pattern <= 16'($urandom() & $urandom()) | 16'h0001;
			endcase
		end else begin
			rx_pattern <= {rx_pattern[0], rx_pattern[15:1]};
		end
		rx_phase <= rx_phase + 5'd1;
		m_tready <= rx_steady | rx_pattern[0];
	end

	// Sends one byte in bursts with random gaps; returns at its accepting edge.
	task automatic send_byte(input logic [7:0] b, input logic eot);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = gaps_on ? $urandom_range(0, 5) : 0;
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= eot;
		do begin
			@(negedge clk);
		end while (!s_tready);
		@(posedge clk);
	endtask

	// Sends n bytes of a packed run, first byte in the highest lane.
	task automatic send_run(input logic [47:0] text, input int unsigned n, input logic eot);
		int unsigned i;
		for (i = n; i > 0; i--) begin
			send_byte(text[8*(i-1) +: 8], eot && (i == 1));
		end
	endtask

	// Holds the input back until every owed code point has come out.
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_points.size() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [7:0] rand_cont();
		return 8'($urandom_range(8'h80, 8'hBF));
	endfunction

	// Random scalar value, often at the edge of its encoded length.
	function automatic logic [CP_W-1:0] random_point();
		logic [CP_W-1:0] lo;
		logic [CP_W-1:0] hi;
		logic [CP_W-1:0] cp;
		case ($urandom_range(0, 3))
			0: begin lo = 21'h0; hi = 21'h7F; end
			1: begin lo = 21'h80; hi = 21'h7FF; end
			2: begin lo = 21'h800; hi = 21'hFFFF; end
			default: begin lo = 21'h10000; hi = 21'h10FFFF; end
		endcase
		if ($urandom_range(0, 3) == 0) begin
			cp = $urandom_range(0, 1) ? lo : hi;
		end else begin
			cp = CP_W'($urandom_range(hi, lo));
		end
		if (cp >= SURR_LO && cp <= SURR_HI) begin
			cp = $urandom_range(0, 1) ? 21'hD7FF : 21'hE000;
		end
		return cp;
	endfunction

	function automatic void encode_point(input logic [CP_W-1:0] cp);
		if (cp < 21'h80) begin
			piece.push_back(cp[7:0]);
		end else if (cp < 21'h800) begin
			piece.push_back({3'b110, cp[10:6]});
			piece.push_back({2'b10, cp[5:0]});
		end else if (cp < 21'h10000) begin
			piece.push_back({4'b1110, cp[15:12]});
			piece.push_back({2'b10, cp[11:6]});
			piece.push_back({2'b10, cp[5:0]});
		end else begin
			piece.push_back({5'b11110, cp[20:18]});
			piece.push_back({2'b10, cp[17:12]});
			piece.push_back({2'b10, cp[11:6]});
			piece.push_back({2'b10, cp[5:0]});
		end
	endfunction

	// Builds one piece of text: mostly well-formed characters, the rest broken.
	function automatic void make_piece();
		piece_kind_e kind;
		int unsigned pos;
		piece.delete();
		if ($urandom_range(0, 99) < 75) begin
			kind = PIECE_VALID;
		end else begin
			kind = piece_kind_e'($urandom_range(PIECE_STRAY_BYTE, PIECE_OUT_OF_RANGE));
		end
		case (kind)
			PIECE_VALID: encode_point(random_point());
			PIECE_STRAY_BYTE: piece.push_back(8'($urandom_range(0, 255)));
			PIECE_CORRUPT_BYTE: begin
				encode_point(random_point());
				pos = $urandom_range(0, piece.size() - 1);
				piece[pos] = 8'($urandom_range(0, 255));
			end
			PIECE_CUT_SHORT: begin
				encode_point(random_point());
				if (piece.size() > 1) begin
					piece.delete(piece.size() - 1);
				end
			end
			PIECE_OVERLONG: begin
				case ($urandom_range(0, 2))
					0: piece.push_back(8'($urandom_range(8'hC0, 8'hC1)));
					1: begin
						piece.push_back(LEAD_E0);
						piece.push_back(8'($urandom_range(8'h80, 8'h9F)));
					end
					default: begin
						piece.push_back(LEAD_F0);
						piece.push_back(8'($urandom_range(8'h80, 8'h8F)));
						piece.push_back(rand_cont());
					end
				endcase
				piece.push_back(rand_cont());
			end
			PIECE_LONG_LEAD: begin
				piece.push_back(8'($urandom_range(8'hF8, 8'hFF)));
				repeat ($urandom_range(4, 5)) piece.push_back(rand_cont());
			end
			default: begin
				case ($urandom_range(0, 2))
					0: begin
						piece.push_back(LEAD_ED);
						piece.push_back(8'($urandom_range(8'hA0, 8'hBF)));
					end
					1: begin
						piece.push_back(LEAD_F4);
						piece.push_back(8'($urandom_range(8'h90, 8'hBF)));
						piece.push_back(rand_cont());
					end
					default: begin
						piece.push_back(8'($urandom_range(8'hF5, 8'hF7)));
						piece.push_back(rand_cont());
						piece.push_back(rand_cont());
					end
				endcase
				piece.push_back(rand_cont());
			end
		endcase
	endfunction

	// Lowest and highest single byte characters; the second one ends the text.
	task automatic test_ascii_extremes();
		send_run(48'h00, 1, 1'b0);
		send_run(48'h7F, 1, 1'b1);
	endtask

	// Highest two and four byte values and a genuine three byte EF BF BD.
	task automatic test_valid_extremes();
		send_run(48'hDF_BF, 2, 1'b0);
		send_run(48'hEF_BF_BD, 3, 1'b0);
		send_run(48'hF4_8F_BF_BF, 4, 1'b0);
	endtask

	// Bad lead, early failing trailing byte, lead above F4, long leads, cut-off text.
	task automatic test_malformed();
		send_run(48'hC0_80, 2, 1'b0);
		send_run(48'hE0_80_80, 3, 1'b0);
		send_run(48'hF5_80_80_80, 4, 1'b0);
		send_run(48'hF8_80_80_80_80, 5, 1'b0);
		send_run(48'hFF_41, 2, 1'b1);
	endtask

	// Random text with both sides idling.
	task automatic test_random_text(input int unsigned n_bytes);
		int unsigned sent;
		logic        end_here;
		sent = 0;
		while (sent < n_bytes) begin
			make_piece();
			end_here = ($urandom_range(0, 11) == 0);
			foreach (piece[i]) begin
				send_byte(piece[i], end_here && (i == piece.size() - 1));
			end
			sent += piece.size();
		end
	endtask

	// Random text at full rate on both sides.
	task automatic test_back_to_back(input int unsigned n_bytes);
		gaps_on = 1'b0;
		rx_steady = 1'b1;
		test_random_text(n_bytes);
		gaps_on = 1'b1;
		rx_steady = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_ascii_extremes();
		test_valid_extremes();
		test_malformed();
		wait_for_results();
		test_random_text(100);
		wait_for_results();
		test_back_to_back(45);
		wait_for_results();
		repeat (DRAIN_TAIL) @(posedge clk);

		if (expected_points.size() != 0) begin
			note_mismatch($sformatf("%0d expected results never arrived",
				expected_points.size()));
		end
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

[files.f]
design/utf8d_pkg.sv
design/utf8d_front.sv
design/utf8d_back.sv
design/utf8_to_code_point_decoder_unit.sv
bench/tb.sv
